FILE: rtl/fixed_step_time_accumulator_core_macros.svh
// Assertion macros shared by the checker of the fixed-step time accumulator.
`ifndef FIXED_STEP_TIME_ACCUMULATOR_CORE_MACROS_SVH
`define FIXED_STEP_TIME_ACCUMULATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define FSTA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define FSTA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fsta_pkg.sv
// Shared types and constants of the fixed-step time accumulator.
`default_nettype none

package fsta_pkg;

    localparam int FSTA_TIME_BITS  = 40;
    localparam int FSTA_ALPHA_BITS = 16;

    localparam int STEP_W     = 32;
    localparam int LIMIT_W    = 16;
    localparam int DROP_OUT_W = 41;
    localparam int TSTEP_W    = 64;
    localparam int TDROP_W    = 48;
    localparam int CFG_IDX_W  = 2;

    localparam logic [STEP_W-1:0]  STEP_RST  = 32'd1000;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd8;
    localparam logic [63:0]        MAT_RST   = 64'd250000;

    localparam logic [TDROP_W-1:0] TDROP_MAX = {TDROP_W{1'b1}};
    localparam logic [TSTEP_W-1:0] TSTEP_MAX = {TSTEP_W{1'b1}};

    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    localparam int OUT_STEP_LO   = 0;
    localparam int OUT_DROP_LO   = OUT_STEP_LO + LIMIT_W;
    localparam int OUT_CLAMP_POS = OUT_DROP_LO + DROP_OUT_W;
    localparam int OUT_ALPHA_LO  = OUT_CLAMP_POS + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_TICKS = 2'd0,
        CFG_MAX_STEPS  = 2'd1,
        CFG_MAX_ACCUM  = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAP,
        ST_LOAD,
        ST_ACC,
        ST_START,
        ST_DIV,
        ST_RUN,
        ST_PROD,
        ST_DROP,
        ST_SUM,
        ST_TOT,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/fsta_cfg.sv
// Configuration registers and their effective values.
`default_nettype none

module fsta_cfg
    import fsta_pkg::*;
#(
    parameter int TIME_BITS = FSTA_TIME_BITS
) (
    input  wire logic                                                i_clk,
    input  wire logic                                                i_rst_n,
    input  wire logic                                                i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]                                i_cfg_index,
    input  wire logic [((TIME_BITS > STEP_W) ? TIME_BITS : STEP_W)-1:0] i_cfg_data,
    output logic [STEP_W-1:0]                                        o_step_eff,
    output logic [LIMIT_W-1:0]                                       o_limit_eff,
    output logic [((TIME_BITS > STEP_W) ? TIME_BITS : STEP_W)-1:0]   o_cap_eff
);

    localparam int ACC_W = (TIME_BITS > STEP_W) ? TIME_BITS : STEP_W;

    logic [STEP_W-1:0]    r_step;
    logic [LIMIT_W-1:0]   r_limit;
    logic [TIME_BITS-1:0] r_mat;
    logic [STEP_W-1:0]    n_step_eff;
    logic [ACC_W-1:0]     n_cap_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_RST;
            r_limit <= LIMIT_RST;
            r_mat   <= TIME_BITS'(MAT_RST);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STEP_TICKS: r_step  <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_STEPS:  r_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_MAX_ACCUM:  r_mat   <= i_cfg_data[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_step_eff = (r_step == '0) ? STEP_W'(1) : r_step;
        n_cap_eff  = (ACC_W'(r_mat) < ACC_W'(n_step_eff)) ? ACC_W'(n_step_eff)
                                                          : ACC_W'(r_mat);
    end

    always_ff @(posedge i_clk) begin
        o_step_eff  <= n_step_eff;
        o_limit_eff <= (r_limit == '0) ? LIMIT_W'(1) : r_limit;
        o_cap_eff   <= n_cap_eff;
    end

endmodule

`default_nettype wire

FILE: rtl/fsta_div.sv
// Restoring divider, one quotient bit per cycle, integer and fraction bits.
`default_nettype none

module fsta_div
    import fsta_pkg::*;
#(
    parameter int INT_W  = 40,
    parameter int FRAC_W = FSTA_ALPHA_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [INT_W-1:0]  i_dividend,
    input  wire logic [STEP_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [INT_W-1:0]       o_quot,
    output logic [FRAC_W-1:0]      o_frac,
    output logic [STEP_W-1:0]      o_rem
);

    localparam int N     = INT_W + FRAC_W;
    localparam int CNT_W = $clog2(N + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [N-1:0]      r_dvd;
    logic [STEP_W-1:0] r_part;
    logic [STEP_W-1:0] r_dsr;
    logic [STEP_W-1:0] r_rem;
    logic [STEP_W:0]   trial;
    logic              ge;
    logic [STEP_W-1:0] n_part;

    always_comb begin
        trial  = {r_part, r_dvd[N-1]};
        ge     = (trial >= {1'b0, r_dsr});
        n_part = ge ? STEP_W'(trial - {1'b0, r_dsr}) : trial[STEP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= {i_dividend, {FRAC_W{1'b0}}};
            r_part <= '0;
            r_dsr  <= i_divisor;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[N-2:0], ge};
            r_part <= n_part;
            if (r_cnt == CNT_W'(INT_W - 1)) begin
                r_rem <= n_part;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd[N-1:FRAC_W];
    assign o_frac = r_dvd[FRAC_W-1:0];
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: rtl/fixed_step_time_accumulator_core.sv
// Top level of the fixed-step time accumulator: sequencer, state and result register.
//
// Input words arrive on s_axis: tuser carries the command (advance or clear),
// tdata carries the signed elapsed time in ticks. Each word yields exactly one
// result word on m_axis: tuser flags whether the time was taken, tdata carries
// the step count, dropped ticks, clamp flag, interpolation fraction and both
// running totals. Configuration is written on the i_cfg channel, which is
// always ready and should only be used while no word is in flight.
// An advance, and a negative delta, runs from acceptance through the capture,
// load, accumulate, start, divide, run, product, drop, sum, total and output
// states; the divider resolves one quotient bit per cycle. A clear skips to output.
// One word is in work at a time; s_axis_tready returns once the result has
// moved into the output register, so a new word may be taken while that
// result still waits. A stalled receiver holds the result and, once the next
// word is finished, the sequencer waits. Reset clears the remainder, the
// totals and the output valid, and loads the register defaults.
`default_nettype none

module fixed_step_time_accumulator_core
    import fsta_pkg::*;
#(
    parameter int TIME_BITS  = FSTA_TIME_BITS,
    parameter int ALPHA_BITS = FSTA_ALPHA_BITS
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // Input word.
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // tdata: delta_ticks, zero padded to whole bytes.
    input  wire logic [((TIME_BITS + 8) / 8) * 8 - 1:0]  s_axis_tdata,
    // tuser: op.
    input  wire logic [0:0]                              s_axis_tuser,
    // Result word.
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // tdata: step_count, dropped_ticks, was_clamped, alpha, total_steps,
    // total_dropped, zero padded to whole bytes.
    output logic [((178 + ALPHA_BITS) / 8) * 8 - 1:0]    m_axis_tdata,
    // tuser: accepted.
    output logic [0:0]                                   m_axis_tuser,
    // Configuration writes.
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]                    i_cfg_index,
    input  wire logic [((TIME_BITS > STEP_W) ? TIME_BITS : STEP_W)-1:0] i_cfg_data
);

    localparam int ACC_W  = (TIME_BITS > STEP_W) ? TIME_BITS : STEP_W;
    localparam int DROP_W = ACC_W + 1;
    localparam int PROD_W = LIMIT_W + STEP_W;
    localparam int PW     = (ACC_W > PROD_W) ? ACC_W : PROD_W;
    localparam int TSUM_W = ((DROP_W > TDROP_W) ? DROP_W : TDROP_W) + 1;
    localparam int RAW_W  = LIMIT_W + DROP_OUT_W + 1 + ALPHA_BITS + 1 + TSTEP_W + TDROP_W;
    localparam int OUT_W  = ((178 + ALPHA_BITS) / 8) * 8;
    localparam logic [ALPHA_BITS:0] ALPHA_ONE = {1'b1, {ALPHA_BITS{1'b0}}};

    logic [STEP_W-1:0]     step_eff;
    logic [LIMIT_W-1:0]    limit_eff;
    logic [ACC_W-1:0]      cap_eff;
    logic                  div_start;
    logic                  div_done;
    logic [ACC_W-1:0]      div_quot;
    logic [ALPHA_BITS-1:0] div_frac;
    logic [STEP_W-1:0]     div_rem;

    t_state r_state, n_state;

    logic                  r_neg, n_neg;
    logic [TIME_BITS-1:0]  r_delta, n_delta;
    logic [ACC_W-1:0]      r_cap, n_cap;
    logic                  r_ge, n_ge;
    logic [ACC_W-1:0]      r_take, n_take;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic [DROP_W-1:0]     r_drop, n_drop;
    logic                  r_clamp, n_clamp;
    logic [ALPHA_BITS:0]   r_alpha, n_alpha;
    logic [ACC_W-1:0]      r_whole, n_whole;
    logic [LIMIT_W-1:0]    r_run, n_run;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic [ACC_W-1:0]      r_ex, n_ex;
    logic [STEP_W-1:0]     r_carried, n_carried;
    logic [TSTEP_W-1:0]    r_tsteps, n_tsteps;
    logic [TDROP_W-1:0]    r_tdrop, n_tdrop;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_user, n_out_user;
    logic [RAW_W-1:0]      r_out_data, n_out_data;

    logic [ACC_W:0]        cap_diff;
    logic [ACC_W:0]        over_diff;
    logic [TSTEP_W:0]      tstep_sum;
    logic [TSUM_W-1:0]     tdrop_sum;

    fsta_cfg #(
        .TIME_BITS(TIME_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_step_eff (step_eff),
        .o_limit_eff(limit_eff),
        .o_cap_eff  (cap_eff)
    );

    fsta_div #(
        .INT_W (ACC_W),
        .FRAC_W(ALPHA_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(r_acc),
        .i_divisor (step_eff),
        .o_done    (div_done),
        .o_quot    (div_quot),
        .o_frac    (div_frac),
        .o_rem     (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_delta     = r_delta;
        n_cap       = r_cap;
        n_ge        = r_ge;
        n_take      = r_take;
        n_acc       = r_acc;
        n_drop      = r_drop;
        n_clamp     = r_clamp;
        n_alpha     = r_alpha;
        n_whole     = r_whole;
        n_run       = r_run;
        n_prod      = r_prod;
        n_ex        = r_ex;
        n_carried   = r_carried;
        n_tsteps    = r_tsteps;
        n_tdrop     = r_tdrop;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_user  = r_out_user;
        n_out_data  = r_out_data;
        div_start   = 1'b0;

        cap_diff  = {1'b0, cap_eff} - {1'b0, ACC_W'(r_carried)};
        over_diff = {1'b0, ACC_W'(r_delta)} - {1'b0, r_cap};
        tstep_sum = {1'b0, r_tsteps} + (TSTEP_W + 1)'(r_run);
        tdrop_sum = TSUM_W'(r_tdrop) + TSUM_W'(r_drop);

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_neg   = s_axis_tdata[TIME_BITS];
                    n_delta = s_axis_tdata[TIME_BITS-1:0];
                    if (s_axis_tuser[0] == OP_CLEAR) begin
                        n_neg     = 1'b0;
                        n_carried = '0;
                        n_tsteps  = '0;
                        n_tdrop   = '0;
                        n_run     = '0;
                        n_drop    = '0;
                        n_clamp   = 1'b0;
                        n_alpha   = '0;
                        n_state   = ST_OUT;
                    end else begin
                        n_state = ST_CAP;
                    end
                end
            end
            ST_CAP: begin
                n_cap   = cap_diff[ACC_W] ? '0 : cap_diff[ACC_W-1:0];
                n_ge    = (r_carried >= step_eff);
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_take  = ACC_W'(r_delta);
                n_drop  = '0;
                n_clamp = 1'b0;
                if (r_neg) begin
                    n_take = '0;
                end else if (!over_diff[ACC_W] && (over_diff != '0)) begin
                    n_take  = r_cap;
                    n_drop  = DROP_W'(over_diff[ACC_W-1:0]);
                    n_clamp = 1'b1;
                end
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_acc   = ACC_W'(r_carried) + r_take;
                n_state = ST_START;
            end
            ST_START: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_alpha = (r_neg && r_ge) ? ALPHA_ONE : {1'b0, div_frac};
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_neg) begin
                    n_run   = '0;
                    n_whole = '0;
                end else begin
                    n_whole   = r_acc - ACC_W'(div_rem);
                    n_carried = div_rem;
                    if (div_quot > ACC_W'(limit_eff)) begin
                        n_run   = limit_eff;
                        n_clamp = 1'b1;
                    end else begin
                        n_run = div_quot[LIMIT_W-1:0];
                    end
                end
                n_state = ST_PROD;
            end
            ST_PROD: begin
                n_prod  = r_run * step_eff;
                n_state = ST_DROP;
            end
            ST_DROP: begin
                n_ex    = ACC_W'(PW'(r_whole) - PW'(r_prod));
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_drop  = r_drop + DROP_W'(r_ex);
                n_state = ST_TOT;
            end
            ST_TOT: begin
                n_tsteps = tstep_sum[TSTEP_W] ? TSTEP_MAX : tstep_sum[TSTEP_W-1:0];
                n_tdrop  = (tdrop_sum > TSUM_W'(TDROP_MAX)) ? TDROP_MAX
                                                            : tdrop_sum[TDROP_W-1:0];
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_user  = !r_neg;
                    n_out_data  = {r_tdrop, r_tsteps, r_alpha, r_clamp,
                                   DROP_OUT_W'(r_drop), r_run};
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carried   <= '0;
            r_tsteps    <= '0;
            r_tdrop     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_carried   <= n_carried;
            r_tsteps    <= n_tsteps;
            r_tdrop     <= n_tdrop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_delta    <= n_delta;
        r_cap      <= n_cap;
        r_ge       <= n_ge;
        r_take     <= n_take;
        r_acc      <= n_acc;
        r_drop     <= n_drop;
        r_clamp    <= n_clamp;
        r_alpha    <= n_alpha;
        r_whole    <= n_whole;
        r_run      <= n_run;
        r_prod     <= n_prod;
        r_ex       <= n_ex;
        r_out_user <= n_out_user;
        r_out_data <= n_out_data;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tdata  = OUT_W'(r_out_data);
    assign o_cfg_ready   = 1'b1;

endmodule

`default_nettype wire

FILE: rtl/fsta_chk.sv
// Port-level checker of the fixed-step time accumulator and its bind.
`default_nettype none

`include "fixed_step_time_accumulator_core_macros.svh"

module fsta_chk
    import fsta_pkg::*;
#(
    parameter int TIME_BITS  = FSTA_TIME_BITS,
    parameter int ALPHA_BITS = FSTA_ALPHA_BITS
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    s_axis_tvalid,
    input  wire logic                                    s_axis_tready,
    // tdata: delta_ticks, zero padded to whole bytes.
    input  wire logic [((TIME_BITS + 8) / 8) * 8 - 1:0]  s_axis_tdata,
    // tuser: op.
    input  wire logic [0:0]                              s_axis_tuser,
    input  wire logic                                    m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // tdata: step_count, dropped_ticks, was_clamped, alpha, total_steps,
    // total_dropped, zero padded to whole bytes.
    input  wire logic [((178 + ALPHA_BITS) / 8) * 8 - 1:0] m_axis_tdata,
    // tuser: accepted.
    input  wire logic [0:0]                              m_axis_tuser,
    input  wire logic                                    i_cfg_valid,
    input  wire logic                                    o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]                    i_cfg_index,
    input  wire logic [((TIME_BITS > STEP_W) ? TIME_BITS : STEP_W)-1:0] i_cfg_data
);

    localparam logic [ALPHA_BITS:0] ALPHA_ONE = {1'b1, {ALPHA_BITS{1'b0}}};

    logic cfg_seen;
    logic in_seen;

    assign cfg_seen = i_cfg_valid && o_cfg_ready && (i_cfg_index != '0 || i_cfg_data != '0);
    assign in_seen  = s_axis_tvalid && (s_axis_tdata != '0 || s_axis_tuser != '0);

    `FSTA_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a word is still in work")

    `FSTA_ASSERT_NOW(a_reject_is_empty, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[OUT_CLAMP_POS:0] == '0, "rejected word reports steps or dropped time")

    `FSTA_ASSERT_NOW(a_drop_needs_clamp, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[OUT_CLAMP_POS], m_axis_tdata[OUT_DROP_LO +: DROP_OUT_W] == '0, "dropped time reported without clamp flag")

    `FSTA_ASSERT_NOW(a_alpha_range, i_clk, i_rst_n, m_axis_tvalid || cfg_seen || in_seen, !m_axis_tvalid || (m_axis_tdata[OUT_ALPHA_LO +: ALPHA_BITS + 1] <= ALPHA_ONE), "interpolation fraction above one")

    `FSTA_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind fixed_step_time_accumulator_core fsta_chk #(
    .TIME_BITS (TIME_BITS),
    .ALPHA_BITS(ALPHA_BITS)
) u_fsta_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .i_cfg_valid  (i_cfg_valid),
    .o_cfg_ready  (o_cfg_ready),
    .i_cfg_index  (i_cfg_index),
    .i_cfg_data   (i_cfg_data)
);

`default_nettype wire
